// ===== rtl/core/imu_ssc_pkg.sv =====
package imu_ssc_pkg;

  localparam int RAW_W     = 16;
  localparam int COEF_W    = 21;
  localparam int PROD_W    = RAW_W + COEF_W;
  localparam int RND_SHIFT = 16;
  localparam int SCALED_W  = 21;
  localparam int OFS_W     = 21;
  localparam int DIFF_W    = OFS_W + 1;
  localparam int ACC_W     = 20;
  localparam int GYRO_W    = 21;
  localparam int TEMP_W    = 17;
  localparam int CNT_W     = 16;
  localparam int CFG_W     = 16;
  localparam int RANGE_W   = 2;
  localparam int SUM_BITS  = 40;
  localparam int NUM_AXES  = 6;
  localparam int NUM_WORDS = 7;
  localparam int IDX_W     = 3;

  // op codes; write also converts, anything else only converts
  localparam logic [1:0] OP_CALIB = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ACCEL_RANGE   = 2'd0;
  localparam logic [1:0] CFG_GYRO_RANGE    = 2'd1;
  localparam logic [1:0] CFG_CALIB_SAMPLES = 2'd2;

  // word order of a sample: accel xyz, temp, gyro xyz
  localparam logic [IDX_W-1:0] WORD_TEMP = 3'd3;
  localparam logic [IDX_W-1:0] WORD_LAST = IDX_W'(NUM_WORDS - 1);
  localparam logic [IDX_W-1:0] AXIS_AZ   = 3'd2;
  localparam logic [IDX_W-1:0] AXIS_LAST = IDX_W'(NUM_AXES - 1);

  localparam logic [CNT_W-1:0] CALIB_SAMPLES_RESET = 16'd256;

  localparam logic signed [COEF_W-1:0] TEMP_RECIP  = 21'sd49345;
  localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 17'sd9352;
  localparam logic signed [DIFF_W-1:0] ONE_G       = 22'sd16384;
  localparam logic signed [PROD_W-1:0] ROUND_HALF  = PROD_W'(2 ** (RND_SHIFT - 1));

  localparam logic signed [DIFF_W-1:0] ACC_MAX  = DIFF_W'(2 ** (ACC_W - 1) - 1);
  localparam logic signed [DIFF_W-1:0] ACC_MIN  = DIFF_W'(-(2 ** (ACC_W - 1)));
  localparam logic signed [DIFF_W-1:0] GYRO_MAX = DIFF_W'(2 ** (GYRO_W - 1) - 1);
  localparam logic signed [DIFF_W-1:0] GYRO_MIN = DIFF_W'(-(2 ** (GYRO_W - 1)));

  localparam logic [SUM_BITS-1:0] QUOT_POS_MAX = SUM_BITS'(2 ** (OFS_W - 1) - 1);
  localparam logic [SUM_BITS-1:0] QUOT_NEG_MAX = SUM_BITS'(2 ** (OFS_W - 1));

  typedef logic signed [RAW_W-1:0]    raw_t;
  typedef logic signed [OFS_W-1:0]    ofs_t;
  typedef logic signed [SUM_BITS-1:0] sum_t;

  // rounded reciprocal of the gyro sensitivity, scaled by 2^16 * 256
  function automatic logic signed [COEF_W-1:0] gyro_recip(input logic [RANGE_W-1:0] range);
    logic signed [COEF_W-1:0] k;
    case (range)
      2'd0:    k = 21'sd128070;
      2'd1:    k = 21'sd256141;
      2'd2:    k = 21'sd511500;
      default: k = 21'sd1023001;
    endcase
    return k;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_accel(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] c;
    c = (v > ACC_MAX) ? ACC_MAX : ((v < ACC_MIN) ? ACC_MIN : v);
    return c[ACC_W-1:0];
  endfunction

  function automatic logic signed [GYRO_W-1:0] sat_gyro(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] c;
    c = (v > GYRO_MAX) ? GYRO_MAX : ((v < GYRO_MIN) ? GYRO_MIN : v);
    return c[GYRO_W-1:0];
  endfunction

  // sign and magnitude quotient to a saturated offset
  function automatic ofs_t quot_to_ofs(input logic neg, input logic [SUM_BITS-1:0] q);
    ofs_t r;
    if (!neg) begin
      r = (q > QUOT_POS_MAX) ? ofs_t'(GYRO_MAX) : ofs_t'(q[OFS_W-1:0]);
    end else begin
      r = (q > QUOT_NEG_MAX) ? ofs_t'(GYRO_MIN) : ofs_t'(~q[OFS_W-1:0] + 1'b1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/imu_sample_scale_calibrate_unit.sv =====
// Each sample's seven words pass in turn through the shared 16x21 multiplier (MUL,
// ACC), then FIN loads the output register. The sample that closes a calibration run
// also runs the bit-serial 40/16 divider per axis (DIV_LOAD, DIV_STEP, DIV_END) to
// build the offsets, and ZADJ takes one g off the z offset. A new sample is taken
// only in IDLE, also while the previous result still waits in the output register.
// Reset (rst, synchronous): ranges 0, calib_samples 256, offsets, sums and count zero.
module imu_sample_scale_calibrate_unit import imu_ssc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [1:0]                 cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 op,
  input  logic signed [RAW_W-1:0]    raw_accel_x,
  input  logic signed [RAW_W-1:0]    raw_accel_y,
  input  logic signed [RAW_W-1:0]    raw_accel_z,
  input  logic signed [RAW_W-1:0]    raw_temp,
  input  logic signed [RAW_W-1:0]    raw_gyro_x,
  input  logic signed [RAW_W-1:0]    raw_gyro_y,
  input  logic signed [RAW_W-1:0]    raw_gyro_z,
  input  logic [IDX_W-1:0]           offset_index,
  input  logic signed [OFS_W-1:0]    offset_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [ACC_W-1:0]    accel_x_g,
  output logic signed [ACC_W-1:0]    accel_y_g,
  output logic signed [ACC_W-1:0]    accel_z_g,
  output logic signed [TEMP_W-1:0]   temp_c,
  output logic signed [GYRO_W-1:0]   gyro_x_dps,
  output logic signed [GYRO_W-1:0]   gyro_y_dps,
  output logic signed [GYRO_W-1:0]   gyro_z_dps,
  output logic                       calibration_done
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [ST_W-1:0] ST_MUL      = 3'd1;
  localparam logic [ST_W-1:0] ST_ACC      = 3'd2;
  localparam logic [ST_W-1:0] ST_DIV_LOAD = 3'd3;
  localparam logic [ST_W-1:0] ST_DIV_STEP = 3'd4;
  localparam logic [ST_W-1:0] ST_DIV_END  = 3'd5;
  localparam logic [ST_W-1:0] ST_ZADJ     = 3'd6;
  localparam logic [ST_W-1:0] ST_FIN      = 3'd7;

  localparam int DIV_CNT_W = $clog2(SUM_BITS);
  localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(SUM_BITS - 1);

  logic [ST_W-1:0]          state;
  logic [IDX_W-1:0]         word;
  logic [IDX_W-1:0]         div_axis;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic [RANGE_W-1:0]       accel_range;
  logic [RANGE_W-1:0]       gyro_range;
  logic [CNT_W-1:0]         calib_samples;
  logic [CNT_W-1:0]         calib_count;
  logic                     op_calib;
  logic                     done_flag;
  ofs_t                     offsets [NUM_AXES];
  sum_t                     sums [NUM_AXES];
  raw_t                     raw [NUM_WORDS];
  logic signed [PROD_W-1:0] prod;
  logic signed [GYRO_W-1:0] res [NUM_AXES];
  logic signed [TEMP_W-1:0] temp_res;
  logic [SUM_BITS-1:0]      dvd;
  logic [CNT_W-1:0]         rem;
  logic                     neg;

  logic                     in_accept;
  logic                     out_load;
  logic                     div_phase;
  logic [IDX_W-1:0]         word_axis;
  logic [IDX_W-1:0]         sel_axis;
  sum_t                     sum_rd;
  ofs_t                     ofs_rd;
  logic signed [COEF_W-1:0] coef;
  logic signed [PROD_W-1:0] rnd;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] zdiff;
  logic [CNT_W-1:0]         count_inc;
  logic [CNT_W-1:0]         n_eff;
  logic                     run_done;
  logic [CNT_W:0]           rem_sh;
  logic                     rem_ge;

  assign in_stall  = rst || (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == ST_FIN) && (!out_valid || !out_stall);

  // accel xyz -> axes 0..2, gyro xyz -> axes 3..5
  assign word_axis = (word < WORD_TEMP) ? word : word - 1'b1;
  assign div_phase = (state == ST_DIV_LOAD) || (state == ST_DIV_STEP) ||
                     (state == ST_DIV_END);
  assign sel_axis  = div_phase ? div_axis : word_axis;
  assign sum_rd    = sums[sel_axis];
  assign ofs_rd    = offsets[word_axis];

  always_comb begin
    if (word < WORD_TEMP) begin
      coef = COEF_W'(1) << accel_range;
    end else if (word == WORD_TEMP) begin
      coef = TEMP_RECIP;
    end else begin
      coef = gyro_recip(gyro_range);
    end
  end

  // accel is an exact shift; temp and gyro round the 16-bit fraction away (round half up)
  assign rnd    = prod + ROUND_HALF;
  assign scaled = (word < WORD_TEMP) ? prod[SCALED_W-1:0]
                                     : rnd[RND_SHIFT +: SCALED_W];
  assign diff   = op_calib ? DIFF_W'(scaled)
                           : DIFF_W'(scaled) - DIFF_W'(ofs_rd);
  assign zdiff  = DIFF_W'(offsets[AXIS_AZ]) - ONE_G;

  assign count_inc = calib_count + 1'b1;
  assign n_eff     = (calib_samples == '0) ? CNT_W'(1) : calib_samples;
  assign run_done  = (count_inc == '0) || (count_inc >= n_eff);

  assign rem_sh = {rem, dvd[SUM_BITS-1]};
  assign rem_ge = rem_sh >= {1'b0, n_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      word          <= '0;
      div_axis      <= '0;
      div_cnt       <= '0;
      accel_range   <= '0;
      gyro_range    <= '0;
      calib_samples <= CALIB_SAMPLES_RESET;
      calib_count   <= '0;
      op_calib      <= 1'b0;
      done_flag     <= 1'b0;
      out_valid     <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        offsets[i] <= '0;
        sums[i]    <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_ACCEL_RANGE:   accel_range   <= cfg_data[RANGE_W-1:0];
          CFG_GYRO_RANGE:    gyro_range    <= cfg_data[RANGE_W-1:0];
          CFG_CALIB_SAMPLES: calib_samples <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            op_calib  <= (op == OP_CALIB);
            done_flag <= 1'b0;
            word      <= '0;
            if (op == OP_WRITE && offset_index < IDX_W'(NUM_AXES)) begin
              offsets[offset_index] <= offset_value;
            end
            // first sample of a run starts from clean offsets and sums
            if (op == OP_CALIB && calib_count == '0) begin
              for (int i = 0; i < NUM_AXES; i++) begin
                offsets[i] <= '0;
                sums[i]    <= '0;
              end
            end
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (op_calib && word != WORD_TEMP) begin
            sums[word_axis] <= sum_rd + SUM_BITS'(scaled);
          end
          if (word == WORD_LAST) begin
            if (op_calib) begin
              calib_count <= run_done ? '0 : count_inc;
              done_flag   <= run_done;
              div_axis    <= '0;
              state       <= run_done ? ST_DIV_LOAD : ST_FIN;
            end else begin
              state <= ST_FIN;
            end
          end else begin
            word  <= word + 1'b1;
            state <= ST_MUL;
          end
        end
        ST_DIV_LOAD: begin
          div_cnt <= '0;
          state   <= ST_DIV_STEP;
        end
        ST_DIV_STEP: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_LAST) begin
            state <= ST_DIV_END;
          end
        end
        ST_DIV_END: begin
          offsets[div_axis] <= quot_to_ofs(neg, dvd);
          if (div_axis == AXIS_LAST) begin
            state <= ST_ZADJ;
          end else begin
            div_axis <= div_axis + 1'b1;
            state    <= ST_DIV_LOAD;
          end
        end
        ST_ZADJ: begin
          offsets[AXIS_AZ] <= sat_gyro(zdiff);
          state            <= ST_FIN;
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath: sample latch, shared multiplier, result and divider registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      raw[0] <= raw_accel_x;
      raw[1] <= raw_accel_y;
      raw[2] <= raw_accel_z;
      raw[3] <= raw_temp;
      raw[4] <= raw_gyro_x;
      raw[5] <= raw_gyro_y;
      raw[6] <= raw_gyro_z;
    end
    if (state == ST_MUL) begin
      prod <= raw[word] * coef;
    end
    if (state == ST_ACC) begin
      if (word == WORD_TEMP) begin
        temp_res <= scaled[TEMP_W-1:0] + TEMP_OFFSET;
      end else if (word < WORD_TEMP) begin
        res[word_axis] <= GYRO_W'(sat_accel(diff));
      end else begin
        res[word_axis] <= sat_gyro(diff);
      end
    end
    // restoring divide of |sum| by n, one quotient bit a cycle
    if (state == ST_DIV_LOAD) begin
      neg <= sum_rd[SUM_BITS-1];
      dvd <= sum_rd[SUM_BITS-1] ? $unsigned(~sum_rd + 1'b1) : $unsigned(sum_rd);
      rem <= '0;
    end
    if (state == ST_DIV_STEP) begin
      rem <= rem_ge ? CNT_W'(rem_sh - {1'b0, n_eff}) : rem_sh[CNT_W-1:0];
      dvd <= {dvd[SUM_BITS-2:0], rem_ge};
    end
    if (out_load) begin
      accel_x_g        <= res[0][ACC_W-1:0];
      accel_y_g        <= res[1][ACC_W-1:0];
      accel_z_g        <= res[2][ACC_W-1:0];
      temp_c           <= temp_res;
      gyro_x_dps       <= res[3];
      gyro_y_dps       <= res[4];
      gyro_z_dps       <= res[5];
      calibration_done <= done_flag;
    end
  end

endmodule

// ===== rtl/core/imu_ssc_checker.sv =====
module imu_ssc_checker import imu_ssc_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [ACC_W-1:0]  accel_x_g,
  input logic signed [TEMP_W-1:0] temp_c,
  input logic signed [GYRO_W-1:0] gyro_z_dps,
  input logic                     calibration_done
);

  // nothing is pending right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result word present after reset");

  // a taken sample keeps the block busy through its first multiply and accumulate states
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input accepted again before the sample was processed");

  // a result appears only at the end of a busy period
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without preceding work");

  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(accel_x_g) && $stable(temp_c) &&
                               $stable(gyro_z_dps) && $stable(calibration_done))
    else $error("result word changed while stalled");

endmodule

bind imu_sample_scale_calibrate_unit imu_ssc_checker u_imu_ssc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .accel_x_g        (accel_x_g),
  .temp_c           (temp_c),
  .gyro_z_dps       (gyro_z_dps),
  .calibration_done (calibration_done)
);
